// ===== hw/rtl/bc_texture_block_decoder_assert.svh =====
// assertion macros for the block decoder
// expects clk and rst_n in scope at the point of use
`ifndef BC_TEXTURE_BLOCK_DECODER_ASSERT_SVH
`define BC_TEXTURE_BLOCK_DECODER_ASSERT_SVH

// condition implies consequence in the same cycle
`define BCTD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define BCTD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bctd_pkg.sv =====
// shared types, codes and fixed-point helpers for the block decoder
// no dependencies
package bctd_pkg;

    localparam int BLOCK_W = 64;
    localparam int COORD_W = 10;
    localparam int PIX_W   = 12;
    localparam int CHAN_W  = 8;
    localparam int DIM_W   = 13;
    localparam int FMT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    // block formats
    localparam logic [FMT_W-1:0] FMT_DXT1  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_DXT1A = 2'd1;
    localparam logic [FMT_W-1:0] FMT_DXT5  = 2'd2;
    localparam logic [FMT_W-1:0] FMT_ATI2  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [FMT_W-1:0] FORMAT_RESET = FMT_DXT5;
    localparam logic [DIM_W-1:0] DIM_RESET    = 13'd4096;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [10:0] rnum_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } rgb_t;

    // round(v * 255 / 31) through a reciprocal multiply
    function automatic chan_t widen5(input logic [4:0] v);
        logic [12:0] x;
        logic [32:0] prod;
        x = {v, 8'd0} - 13'(v) + 13'd15;
        prod = 33'(x) * 33'd33826;
        return prod[27:20];
    endfunction

    // round(v * 255 / 63) through a reciprocal multiply
    function automatic chan_t widen6(input logic [5:0] v);
        logic [13:0] x;
        logic [28:0] prod;
        x = {v, 8'd0} - 14'(v) + 14'd31;
        prod = 29'(x) * 29'd16645;
        return prod[27:20];
    endfunction

    // floor(x / 3) for x up to 765
    function automatic chan_t div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'(x) * 20'd683;
        return prod[18:11];
    endfunction

    // floor(x / 5) for x up to 1275
    function automatic chan_t div5(input rnum_t x);
        logic [22:0] prod;
        prod = 23'(x) * 23'd3277;
        return prod[21:14];
    endfunction

    // floor(x / 7) for x up to 1785
    function automatic chan_t div7(input rnum_t x);
        logic [22:0] prod;
        prod = 23'(x) * 23'd2341;
        return prod[21:14];
    endfunction

endpackage

// ===== hw/rtl/bctd_if.sv =====
// valid/ready channels for compressed blocks in and pixels out
// depends on bctd_pkg
interface bctd_block_if;
    import bctd_pkg::*;

    logic               valid;
    logic               ready;
    logic [BLOCK_W-1:0] block_low;
    logic [BLOCK_W-1:0] block_high;
    logic [COORD_W-1:0] block_col;
    logic [COORD_W-1:0] block_row;

    modport source (output valid, block_low, block_high, block_col, block_row,
                    input ready);
    modport sink   (input valid, block_low, block_high, block_col, block_row,
                    output ready);
endinterface

interface bctd_pixel_if;
    import bctd_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    chan_t            red;
    chan_t            green;
    chan_t            blue;
    chan_t            alpha;
    logic             last;

    modport source (output valid, pixel_x, pixel_y, red, green, blue, alpha, last,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, red, green, blue, alpha, last,
                    output ready);
endinterface

// ===== hw/rtl/bc_texture_block_decoder.sv =====
// Block decoder: 4x4 compressed block in, clipped RGBA8 pixels out in raster order.
// The first pixel of a block passes the input, endpoint, palette, serializer and output
// registers after the block request is taken. Pixels leave at one per cycle while the
// output is not stalled; an interior block yields 16 and a fully clipped one none.
// Blocks overlap: endpoint, palette and serializer stages each hold a different block.
// Reset (rst_n, async low) empties every stage; format DXT5, width and height 4096.
module bc_texture_block_decoder #(
    parameter int MAX_DIM = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bctd_block_if.sink                         blocks,
    bctd_pixel_if.source                       pixels,
    input  logic                               cfg_write,
    input  logic [bctd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bctd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bctd_pkg::*;

`include "bc_texture_block_decoder_assert.svh"

    localparam int LIM_W = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_DIM);

    // configuration
    logic [FMT_W-1:0] cfg_format_reg;
    logic [DIM_W-1:0] cfg_width_reg;
    logic [DIM_W-1:0] cfg_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_format_reg <= FORMAT_RESET;
            cfg_width_reg  <= DIM_RESET;
            cfg_height_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FORMAT: cfg_format_reg <= cfg_data[FMT_W-1:0];
                CFG_WIDTH:  cfg_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: cfg_height_reg <= cfg_data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // stage handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, ser_busy_reg, out_valid_reg;
    logic s1_en, s2_en, s3_en, ser_take, out_free, pix_fire, ser_final;

    // stage 1: input register
    logic [BLOCK_W-1:0] s1_low_reg, s1_high_reg;
    logic [COORD_W-1:0] s1_col_reg, s1_row_reg;

    // stage 2: widened endpoints, ramp numerators, clip extents
    rgb_t               s2_e_reg [2];
    logic               s2_three_reg;
    chan_t              s2_be_reg [2][2];
    logic               s2_gt_reg [2];
    rnum_t              s2_num_reg [2][2:7];
    logic [31:0]        s2_csel_reg;
    logic [47:0]        s2_asel_reg [2];
    logic [COORD_W-1:0] s2_col_reg, s2_row_reg;
    logic [1:0]         s2_xl_reg, s2_yl_reg;
    logic               s2_empty_reg;

    // stage 3: palettes and ramps
    rgb_t               s3_pal_reg [4];
    logic               s3_three_reg;
    chan_t              s3_ramp_reg [2][8];
    logic [31:0]        s3_csel_reg;
    logic [47:0]        s3_asel_reg [2];
    logic [COORD_W-1:0] s3_col_reg, s3_row_reg;
    logic [1:0]         s3_xl_reg, s3_yl_reg;
    logic               s3_empty_reg;

    // serializer
    rgb_t               ser_pal_reg [4];
    logic               ser_three_reg;
    chan_t              ser_ramp_reg [2][8];
    logic [31:0]        ser_csel_reg;
    logic [47:0]        ser_asel_reg [2];
    logic [COORD_W-1:0] ser_col_reg, ser_row_reg;
    logic [1:0]         ser_xl_reg, ser_yl_reg;
    logic [1:0]         ser_cx_reg, ser_cy_reg;

    // output register
    logic [PIX_W-1:0]   out_x_reg, out_y_reg;
    chan_t              out_r_reg, out_g_reg, out_b_reg, out_a_reg;
    logic               out_last_reg;

    assign out_free  = !out_valid_reg || pixels.ready;
    assign ser_final = (ser_cx_reg == ser_xl_reg) && (ser_cy_reg == ser_yl_reg);
    assign pix_fire  = ser_busy_reg && out_free;
    assign ser_take  = !ser_busy_reg || (pix_fire && ser_final);
    assign s3_en     = !s3_valid_reg || ser_take;
    assign s2_en     = !s2_valid_reg || s3_en;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign blocks.ready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= blocks.valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && blocks.valid)
        begin
            s1_low_reg  <= blocks.block_low;
            s1_high_reg <= blocks.block_high;
            s1_col_reg  <= blocks.block_col;
            s1_row_reg  <= blocks.block_row;
        end
    end

    // stage 2 logic
    logic [BLOCK_W-1:0] chalf;
    logic [15:0]        c0, c1;
    logic [BLOCK_W-1:0] hv [2];
    rgb_t               e_next [2];
    logic               three_next;
    logic               gt_next [2];
    rnum_t              num_next [2][2:7];
    logic [LIM_W-1:0]   wlim, hlim, x0, y0, xrem, yrem;
    logic               x_in, y_in;
    logic [1:0]         xl_next, yl_next;

    always_comb
    begin
        chalf = (cfg_format_reg == FMT_DXT5) ? s1_high_reg : s1_low_reg;
        c0 = chalf[15:0];
        c1 = chalf[31:16];
        e_next[0].r = widen5(c0[15:11]);
        e_next[0].g = widen6(c0[10:5]);
        e_next[0].b = widen5(c0[4:0]);
        e_next[1].r = widen5(c1[15:11]);
        e_next[1].g = widen6(c1[10:5]);
        e_next[1].b = widen5(c1[4:0]);
        three_next = (cfg_format_reg == FMT_DXT1A) && (c0 <= c1);

        hv[0] = s1_low_reg;
        hv[1] = s1_high_reg;
        for (int h = 0; h < 2; h++)
        begin
            gt_next[h] = hv[h][7:0] > hv[h][15:8];
            for (int k = 2; k < 8; k++)
            begin
                if (gt_next[h])
                    num_next[h][k] = rnum_t'(hv[h][7:0]) * rnum_t'(8 - k)
                                   + rnum_t'(hv[h][15:8]) * rnum_t'(k - 1);
                else if (k <= 5)
                    num_next[h][k] = rnum_t'(hv[h][7:0]) * rnum_t'(6 - k)
                                   + rnum_t'(hv[h][15:8]) * rnum_t'(k - 1);
                else
                    num_next[h][k] = '0;
            end
        end

        // visible extent of the block inside the image
        wlim = (LIM_W'(cfg_width_reg) < MAX_LIM) ? LIM_W'(cfg_width_reg) : MAX_LIM;
        hlim = (LIM_W'(cfg_height_reg) < MAX_LIM) ? LIM_W'(cfg_height_reg) : MAX_LIM;
        x0 = LIM_W'({s1_col_reg, 2'b00});
        y0 = LIM_W'({s1_row_reg, 2'b00});
        x_in = x0 < wlim;
        y_in = y0 < hlim;
        xrem = wlim - x0;
        yrem = hlim - y0;
        xl_next = (xrem > LIM_W'(3)) ? 2'd3 : 2'(xrem[1:0] - 2'd1);
        yl_next = (yrem > LIM_W'(3)) ? 2'd3 : 2'(yrem[1:0] - 2'd1);
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_e_reg     <= e_next;
            s2_three_reg <= three_next;
            for (int h = 0; h < 2; h++)
            begin
                s2_be_reg[h][0] <= hv[h][7:0];
                s2_be_reg[h][1] <= hv[h][15:8];
                s2_gt_reg[h]    <= gt_next[h];
                s2_asel_reg[h]  <= hv[h][63:16];
                for (int k = 2; k < 8; k++)
                    s2_num_reg[h][k] <= num_next[h][k];
            end
            s2_csel_reg  <= chalf[63:32];
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
            s2_xl_reg    <= xl_next;
            s2_yl_reg    <= yl_next;
            s2_empty_reg <= !x_in || !y_in;
        end
    end

    // stage 3 logic
    rgb_t  pal_next [4];
    chan_t ramp_next [2][8];

    always_comb
    begin
        pal_next[0] = s2_e_reg[0];
        pal_next[1] = s2_e_reg[1];
        if (s2_three_reg)
        begin
            pal_next[2].r = chan_t'(({1'b0, s2_e_reg[0].r} + {1'b0, s2_e_reg[1].r}) >> 1);
            pal_next[2].g = chan_t'(({1'b0, s2_e_reg[0].g} + {1'b0, s2_e_reg[1].g}) >> 1);
            pal_next[2].b = chan_t'(({1'b0, s2_e_reg[0].b} + {1'b0, s2_e_reg[1].b}) >> 1);
            pal_next[3]   = '0;
        end
        else
        begin
            pal_next[2].r = div3({1'b0, s2_e_reg[0].r, 1'b0} + 10'(s2_e_reg[1].r));
            pal_next[2].g = div3({1'b0, s2_e_reg[0].g, 1'b0} + 10'(s2_e_reg[1].g));
            pal_next[2].b = div3({1'b0, s2_e_reg[0].b, 1'b0} + 10'(s2_e_reg[1].b));
            pal_next[3].r = div3(10'(s2_e_reg[0].r) + {1'b0, s2_e_reg[1].r, 1'b0});
            pal_next[3].g = div3(10'(s2_e_reg[0].g) + {1'b0, s2_e_reg[1].g, 1'b0});
            pal_next[3].b = div3(10'(s2_e_reg[0].b) + {1'b0, s2_e_reg[1].b, 1'b0});
        end

        for (int h = 0; h < 2; h++)
        begin
            ramp_next[h][0] = s2_be_reg[h][0];
            ramp_next[h][1] = s2_be_reg[h][1];
            for (int k = 2; k < 8; k++)
            begin
                if (s2_gt_reg[h])
                    ramp_next[h][k] = div7(s2_num_reg[h][k]);
                else if (k == 6)
                    ramp_next[h][k] = 8'd0;
                else if (k == 7)
                    ramp_next[h][k] = 8'd255;
                else
                    ramp_next[h][k] = div5(s2_num_reg[h][k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en && s2_valid_reg)
        begin
            s3_pal_reg   <= pal_next;
            s3_three_reg <= s2_three_reg;
            s3_ramp_reg  <= ramp_next;
            s3_csel_reg  <= s2_csel_reg;
            s3_asel_reg  <= s2_asel_reg;
            s3_col_reg   <= s2_col_reg;
            s3_row_reg   <= s2_row_reg;
            s3_xl_reg    <= s2_xl_reg;
            s3_yl_reg    <= s2_yl_reg;
            s3_empty_reg <= s2_empty_reg;
        end
    end

    // serializer: walks the visible pixels of one block, one per cycle while the output register is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_busy_reg <= 1'b0;
            ser_cx_reg   <= 2'd0;
            ser_cy_reg   <= 2'd0;
        end
        else if (ser_take)
        begin
            ser_busy_reg <= s3_valid_reg && !s3_empty_reg;
            ser_cx_reg   <= 2'd0;
            ser_cy_reg   <= 2'd0;
        end
        else if (pix_fire)
        begin
            if (ser_cx_reg == ser_xl_reg)
            begin
                ser_cx_reg <= 2'd0;
                ser_cy_reg <= ser_cy_reg + 2'd1;
            end
            else
                ser_cx_reg <= ser_cx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_take && s3_valid_reg)
        begin
            ser_pal_reg   <= s3_pal_reg;
            ser_three_reg <= s3_three_reg;
            ser_ramp_reg  <= s3_ramp_reg;
            ser_csel_reg  <= s3_csel_reg;
            ser_asel_reg  <= s3_asel_reg;
            ser_col_reg   <= s3_col_reg;
            ser_row_reg   <= s3_row_reg;
            ser_xl_reg    <= s3_xl_reg;
            ser_yl_reg    <= s3_yl_reg;
        end
    end

    // pixel select
    logic [3:0] pidx;
    logic [5:0] abase;
    logic [1:0] ci;
    logic [2:0] sel_lo, sel_hi;
    chan_t      pr, pg, pb, pa;

    always_comb
    begin
        pidx   = {ser_cy_reg, ser_cx_reg};
        abase  = {2'b00, pidx} + {1'b0, pidx, 1'b0};
        ci     = ser_csel_reg[{pidx, 1'b0} +: 2];
        sel_lo = ser_asel_reg[0][abase +: 3];
        sel_hi = ser_asel_reg[1][abase +: 3];
        if (cfg_format_reg == FMT_ATI2)
        begin
            pr = ser_ramp_reg[0][sel_lo];
            pg = ser_ramp_reg[1][sel_hi];
            pb = 8'd0;
            pa = 8'd255;
        end
        else
        begin
            pr = ser_pal_reg[ci].r;
            pg = ser_pal_reg[ci].g;
            pb = ser_pal_reg[ci].b;
            if (cfg_format_reg == FMT_DXT5)
                pa = ser_ramp_reg[0][sel_lo];
            else if (ser_three_reg && (ci == 2'd3))
                pa = 8'd0;
            else
                pa = 8'd255;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= pix_fire;
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            out_x_reg    <= {ser_col_reg, ser_cx_reg};
            out_y_reg    <= {ser_row_reg, ser_cy_reg};
            out_r_reg    <= pr;
            out_g_reg    <= pg;
            out_b_reg    <= pb;
            out_a_reg    <= pa;
            out_last_reg <= ser_final;
        end
    end

    assign pixels.valid   = out_valid_reg;
    assign pixels.pixel_x = out_x_reg;
    assign pixels.pixel_y = out_y_reg;
    assign pixels.red     = out_r_reg;
    assign pixels.green   = out_g_reg;
    assign pixels.blue    = out_b_reg;
    assign pixels.alpha   = out_a_reg;
    assign pixels.last    = out_last_reg;

    `BCTD_ASSERT_NEXT(a_take_fills_s1, blocks.valid && blocks.ready, s1_valid_reg,
        "accepted block did not reach the input stage")
    `BCTD_ASSERT_NOW(a_walk_in_extent, ser_busy_reg,
        (ser_cx_reg <= ser_xl_reg) && (ser_cy_reg <= ser_yl_reg),
        "serializer position outside the visible extent")
    `BCTD_ASSERT_NOW(a_pixel_clipped, pixels.valid,
        (LIM_W'(pixels.pixel_x) < wlim) && (LIM_W'(pixels.pixel_y) < hlim),
        "emitted pixel lies outside the image")

endmodule

// ===== test/tb_top.sv =====
// self-checking bench for bc_texture_block_decoder: compressed blocks in, checked RGBA pixels out
// depends on bctd_pkg and the two channel interfaces of bctd_if.sv
// an in-bench decoder predicts every pixel, a scoreboard queue holds them in arrival order
module tb_top;
    import bctd_pkg::*;

    localparam int          MAX_DIM    = 4096;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          SETTLE     = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [BLOCK_W-1:0] low;
        logic [BLOCK_W-1:0] high;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } block_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        chan_t            red;
        chan_t            green;
        chan_t            blue;
        chan_t            alpha;
        logic             last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bctd_block_if blk_ch ();
    bctd_pixel_if pix_ch ();

    bc_texture_block_decoder #(
        .MAX_DIM(MAX_DIM)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .blocks   (blk_ch),
        .pixels   (pix_ch),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // register shadow, reset values
    logic [FMT_W-1:0] cur_format = FMT_DXT5;
    int unsigned      cur_width  = 4096;
    int unsigned      cur_height = 4096;

    block_req_t  pending_blocks[$];
    pixel_t      expected_pixels[$];
    bit          presenting = 1'b0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic chan_t widen_5bit(input logic [4:0] v);
        int unsigned t;
        t = (int'(v) * 255 + 15) / 31;
        return chan_t'(t);
    endfunction

    function automatic chan_t widen_6bit(input logic [5:0] v);
        int unsigned t;
        t = (int'(v) * 255 + 31) / 63;
        return chan_t'(t);
    endfunction

    // eight-level ramp channel of a half block, pixel p
    function automatic chan_t ramp_channel(input logic [63:0] half, input int p);
        int unsigned e0;
        int unsigned e1;
        int unsigned sel;
        int unsigned v;
        e0  = 32'(half[7:0]);
        e1  = 32'(half[15:8]);
        sel = 32'(half[16 + 3 * p +: 3]);
        if (sel == 0)
            v = e0;
        else if (sel == 1)
            v = e1;
        else if (e0 > e1)
            v = ((8 - sel) * e0 + (sel - 1) * e1) / 7;
        else if (sel == 6)
            v = 0;
        else if (sel == 7)
            v = 255;
        else
            v = ((6 - sel) * e0 + (sel - 1) * e1) / 5;
        return chan_t'(v);
    endfunction

    // palette entry ci of a 565 color half block, alpha included
    function automatic pixel_t color_entry(input logic [63:0] half, input bit three_ok,
                                           input int unsigned ci);
        int unsigned lo_ep[3];
        int unsigned hi_ep[3];
        int unsigned v[3];
        bit          four;
        pixel_t      px;
        lo_ep[0] = 32'(widen_5bit(half[15:11]));
        lo_ep[1] = 32'(widen_6bit(half[10:5]));
        lo_ep[2] = 32'(widen_5bit(half[4:0]));
        hi_ep[0] = 32'(widen_5bit(half[31:27]));
        hi_ep[1] = 32'(widen_6bit(half[26:21]));
        hi_ep[2] = 32'(widen_5bit(half[20:16]));
        four = (half[15:0] > half[31:16]) || !three_ok;
        for (int ch = 0; ch < 3; ch++)
        begin
            case (ci)
                0: v[ch] = lo_ep[ch];
                1: v[ch] = hi_ep[ch];
                2: v[ch] = four ? (2 * lo_ep[ch] + hi_ep[ch]) / 3 : (lo_ep[ch] + hi_ep[ch]) / 2;
                default: v[ch] = four ? (lo_ep[ch] + 2 * hi_ep[ch]) / 3 : 0;
            endcase
        end
        px       = '0;
        px.red   = chan_t'(v[0]);
        px.green = chan_t'(v[1]);
        px.blue  = chan_t'(v[2]);
        px.alpha = (ci == 3 && !four) ? 8'd0 : 8'd255;
        return px;
    endfunction

    // queue the visible pixels of one accepted block
    task automatic decode_block(input block_req_t req);
        int unsigned wlim;
        int unsigned hlim;
        int unsigned x;
        int unsigned y;
        int          last_p;
        logic [63:0] half;
        pixel_t      px;
        wlim = (cur_width < MAX_DIM) ? cur_width : MAX_DIM;
        hlim = (cur_height < MAX_DIM) ? cur_height : MAX_DIM;
        last_p = -1;
        for (int p = 0; p < 16; p++)
        begin
            x = int'(req.col) * 4 + p % 4;
            y = int'(req.row) * 4 + p / 4;
            if (x < wlim && y < hlim)
                last_p = p;
        end
        for (int p = 0; p < 16; p++)
        begin
            x = int'(req.col) * 4 + p % 4;
            y = int'(req.row) * 4 + p / 4;
            if (x < wlim && y < hlim)
            begin
                if (cur_format == FMT_ATI2)
                begin
                    px       = '0;
                    px.red   = ramp_channel(req.low, p);
                    px.green = ramp_channel(req.high, p);
                    px.blue  = 8'd0;
                    px.alpha = 8'd255;
                end
                else
                begin
                    half = (cur_format == FMT_DXT5) ? req.high : req.low;
                    px = color_entry(half, cur_format == FMT_DXT1A,
                                     32'(half[32 + 2 * p +: 2]));
                    if (cur_format == FMT_DXT5)
                        px.alpha = ramp_channel(req.low, p);
                end
                px.x    = PIX_W'(x);
                px.y    = PIX_W'(y);
                px.last = (p == last_p);
                expected_pixels.push_back(px);
            end
        end
    endtask

    task automatic report_error(input string what, input pixel_t want, input pixel_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0d: %s exp x=%0d y=%0d rgba=%02h%02h%02h%02h last=%0b",
                     cycle_count, what, want.x, want.y, want.red, want.green, want.blue,
                     want.alpha, want.last);
            $display("%0d: %s got x=%0d y=%0d rgba=%02h%02h%02h%02h last=%0b",
                     cycle_count, what, got.x, got.y, got.red, got.green, got.blue,
                     got.alpha, got.last);
        end
    endtask

    // block request side: acceptance and prediction at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && blk_ch.valid && blk_ch.ready)
        begin
            decode_block(pending_blocks[0]);
            void'(pending_blocks.pop_front());
            presenting = 1'b0;
        end
    end

    // block request side: drive at the falling edge, hold until taken
    always @(negedge clk)
    begin
        if (rst_n && !presenting)
        begin
            if (pending_blocks.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                blk_ch.block_low  <= pending_blocks[0].low;
                blk_ch.block_high <= pending_blocks[0].high;
                blk_ch.block_col  <= pending_blocks[0].col;
                blk_ch.block_row  <= pending_blocks[0].row;
                blk_ch.valid      <= 1'b1;
                presenting = 1'b1;
            end
            else
                blk_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        pix_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // pixel monitor
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            got.x     = pix_ch.pixel_x;
            got.y     = pix_ch.pixel_y;
            got.red   = pix_ch.red;
            got.green = pix_ch.green;
            got.blue  = pix_ch.blue;
            got.alpha = pix_ch.alpha;
            got.last  = pix_ch.last;
            if (expected_pixels.size() == 0)
                report_error("unexpected pixel", '0, got);
            else
            begin
                want = expected_pixels.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.red !== want.red ||
                    got.green !== want.green || got.blue !== want.blue ||
                    got.alpha !== want.alpha || got.last !== want.last)
                    report_error("pixel mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        case (idx)
            CFG_FORMAT: cur_format = FMT_W'(value);
            CFG_WIDTH:  cur_width  = value & 32'h1FFF;
            CFG_HEIGHT: cur_height = value & 32'h1FFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(input logic [FMT_W-1:0] fmt, input int unsigned w,
                             input int unsigned h);
        write_reg(CFG_FORMAT, 32'(fmt));
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // all requests taken, all pixels seen, then let the pipe empty
    task automatic drain();
        while (pending_blocks.size() != 0 || presenting || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic add_block(input logic [63:0] lo, input logic [63:0] hi,
                             input int unsigned col, input int unsigned row);
        block_req_t req;
        req.low  = lo;
        req.high = hi;
        req.col  = COORD_W'(col);
        req.row  = COORD_W'(row);
        pending_blocks.push_back(req);
    endtask

    // mostly within the image or just past its edge, sometimes anywhere
    function automatic int unsigned pick_coord(input int unsigned lim);
        int unsigned top;
        if (lim == 0 || $urandom_range(3) == 0)
            return $urandom_range(1023);
        top = (lim >= MAX_DIM) ? 1023 : lim / 4;
        return $urandom_range(top);
    endfunction

    function automatic int unsigned pick_dim();
        case ($urandom_range(5))
            0: return 1;
            1: return 4096;
            2: return 8191;
            3: return $urandom_range(64, 2);
            4: return $urandom_range(4200, 4000);
            default: return $urandom_range(4096, 1);
        endcase
    endfunction

    task automatic add_random_blocks(input int count);
        logic [63:0] lo;
        logic [63:0] hi;
        int unsigned wlim;
        int unsigned hlim;
        wlim = (cur_width < MAX_DIM) ? cur_width : MAX_DIM;
        hlim = (cur_height < MAX_DIM) ? cur_height : MAX_DIM;
        repeat (count)
        begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            case ($urandom_range(5))
                0: lo[31:16] = lo[15:0];  // equal color endpoints
                1: hi[31:16] = hi[15:0];
                2:
                begin
                    lo[15:8] = lo[7:0];   // flat ramps
                    hi[15:8] = hi[7:0];
                end
                default: ;
            endcase
            add_block(lo, hi, pick_coord(wlim), pick_coord(hlim));
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct  = 83;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 83;
            end
            default:
            begin
                idle_pct  = 30;
                stall_pct = 30;
            end
        endcase
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = CFG_FORMAT;
        cfg_data          = '0;
        blk_ch.valid      = 1'b0;
        blk_ch.block_low  = '0;
        blk_ch.block_high = '0;
        blk_ch.block_col  = '0;
        blk_ch.block_row  = '0;
        pix_ch.ready      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: DXT5, full 4096 image
        set_idling(0);
        add_block(64'h0, 64'h0, 0, 0);
        add_block('1, '1, 1023, 1023);
        add_block({48'hFAC688_FAC688, 8'h10, 8'hF0}, {32'hE4E4E4E4, 16'h07E0, 16'hF800}, 5, 9);
        add_block({48'h053977_053977, 8'hC0, 8'h20}, {32'h1B1B1B1B, 16'hFFFF, 16'h001F}, 1023, 0);
        add_block({48'h123456_789ABC, 8'h80, 8'h80}, {32'h9C9C9C9C, 16'h8410, 16'h8410},
                  0, 1023);
        drain();

        // DXT1 is four-color whatever the endpoint order
        configure(FMT_DXT1, 4096, 4096);
        add_block({32'hE4E4E4E4, 16'h001F, 16'hFFE0}, '1, 7, 3);
        add_block({32'hE4E4E4E4, 16'hF81F, 16'h07E0}, 64'h0, 100, 200);
        add_block({32'hFFFFFFFF, 16'h8410, 16'h8410}, 64'h0, 2, 2);
        add_block(64'h0, 64'h0, 1023, 0);
        add_block('1, 64'h0, 0, 1023);
        drain();

        // DXT1A on a 10x7 image: partial and fully clipped blocks
        configure(FMT_DXT1A, 10, 7);
        add_block({32'hE4E4E4E4, 16'hF81F, 16'h07E0}, 64'h0, 0, 0);
        add_block({32'hFFFFFFFF, 16'h4208, 16'h4208}, 64'h0, 0, 0);
        add_block({32'hE4E4E4E4, 16'h001F, 16'hFFE0}, 64'h0, 1, 1);
        add_block({32'h1B1BE4E4, 16'hFFFF, 16'h0000}, 64'h0, 2, 1);
        add_block('1, '1, 3, 0);
        add_block(64'h0, 64'h0, 0, 2);
        add_block('1, 64'h0, 2, 0);
        drain();

        // ATI2, dimensions above the limit clip to MAX_DIM
        configure(FMT_ATI2, 8191, 8191);
        add_block({48'hFAC688_FAC688, 8'h10, 8'hF0}, {48'h053977_053977, 8'hFF, 8'h00},
                  1023, 1023);
        add_block(64'h0, '1, 0, 0);
        add_block({48'hFFFFFF_000000, 8'h55, 8'h55}, {48'h924924_924924, 8'h00, 8'hFF},
                  512, 511);
        drain();

        // zero width or height emits nothing; a write to an unused index is dropped
        configure(FMT_DXT1, 0, 4096);
        add_block('1, '1, 0, 0);
        add_block(64'h0, 64'h0, 1023, 1023);
        drain();
        write_reg(CFG_UNUSED, 32'h1FFF);
        configure(FMT_DXT5, 1, 0);
        add_block('1, '1, 0, 0);
        drain();
        configure(FMT_DXT5, 1, 1);
        add_block({48'hFAC688_FAC688, 8'h10, 8'hF0}, {32'h00000003, 16'h001F, 16'hFFE0}, 0, 0);
        drain();

        for (int m = 0; m < 8; m++)
        begin
            configure(FMT_W'((m + m / 4) % 4), pick_dim(), pick_dim());
            set_idling(m % 4);
            add_random_blocks(10);
            drain();
        end

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
